// File: src/dsched_pkg.sv
// package for the disk request scheduler
// types, codes and constants; depends on nothing
package dsched_pkg;

   localparam int unsigned POOL_DEPTH_DEF = 16;
   localparam int unsigned CYL_BITS_DEF = 14;
   localparam int unsigned CSR_ADDR_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic [CYL_BITS_DEF-1:0] START_RESET = CYL_BITS_DEF'(5000);
   localparam logic [CYL_BITS_DEF-1:0] TOP_RESET = CYL_BITS_DEF'(9999);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_POLICY = 2'd0,
      CSR_START  = 2'd1,
      CSR_TOP    = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      POL_FCFS  = 3'd0,
      POL_SSTF  = 3'd1,
      POL_SCAN  = 3'd2,
      POL_CSCAN = 3'd3,
      POL_LOOK  = 3'd4,
      POL_CLOOK = 3'd5,
      POL_RSV6  = 3'd6,
      POL_RSV7  = 3'd7
   } policy_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_SHIFT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [CYL_BITS_DEF-1:0] cylinder;
      logic                    end_of_requests;
   } req_word_type;

   typedef struct packed {
      logic [CYL_BITS_DEF-1:0] served_cylinder;
      logic [31:0]             head_movement;
      logic                    run_last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic store;       // append request word
      logic scan_start;  // clear search bests
      logic scan_step;   // evaluate one slot
      logic pick;        // commit choice, update head and total
      logic shift_step;  // close the gap one slot
      logic shift_done;  // drop count
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pool_full;
      logic pool_empty;
      logic pool_one;    // exactly one request pending
      logic scan_last;
      logic shift_last;
   } dp_status_type;

endpackage

// File: src/dsched_ctrl.sv
// controller state machine for the disk request scheduler
// depends on dsched_pkg
module dsched_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_last,
   output dsched_pkg::dp_cmd_type    cmd,
   input  dsched_pkg::dp_status_type status
);

   dsched_pkg::state_type state_ff, state_in;
   logic drain_ff, drain_in;
   logic store_ff, store_in;   // arrival still to be stored after a service
   logic last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsched_pkg::ST_IDLE;
         drain_ff <= 1'b0;
         store_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
         store_ff <= store_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      drain_in = drain_ff;
      store_in = store_ff;
      last_in = last_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last = last_ff;
      case (state_ff)
         dsched_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               drain_in = req_end;
               if (status.pool_full) begin
                  store_in = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in = dsched_pkg::ST_SCAN;
               end else begin
                  cmd.store = 1'b1;
                  if (req_end) begin
                     cmd.scan_start = 1'b1;
                     state_in = dsched_pkg::ST_SCAN;
                  end
               end
            end
         end
         dsched_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = dsched_pkg::ST_PICK;
         end
         dsched_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = dsched_pkg::ST_SHIFT;
         end
         dsched_pkg::ST_SHIFT: begin
            if (status.shift_last) begin
               cmd.shift_done = 1'b1;
               // last result: drain serves its final request, or a non-drain service
               last_in = drain_ff ? (status.pool_one && !store_ff) : 1'b1;
               state_in = dsched_pkg::ST_OUT;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         dsched_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (store_ff) begin
                  cmd.store = 1'b1;
                  store_in = 1'b0;
               end
               if (drain_ff && !(status.pool_empty && !store_ff)) begin
                  cmd.scan_start = 1'b1;
                  state_in = dsched_pkg::ST_SCAN;
               end else begin
                  drain_in = 1'b0;
                  state_in = dsched_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = dsched_pkg::ST_IDLE;
      endcase
   end

   // a result is shown only in the output state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == dsched_pkg::ST_OUT)
      else $error("result outside output state");
   // no arrival taken while a service is in progress
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !store_ff)
      else $error("arrival taken with one still pending");
   // a held result keeps its last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_last))
      else $error("held result changed");

endmodule

// File: src/dsched_dp.sv
// datapath of the disk request scheduler: pool, search, head and total
// depends on dsched_pkg
module dsched_dp #(
   parameter int unsigned POOL_DEPTH = dsched_pkg::POOL_DEPTH_DEF,
   parameter int unsigned CYL_BITS = dsched_pkg::CYL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dsched_pkg::dp_cmd_type    cmd,
   output dsched_pkg::dp_status_type status,
   input  logic [CYL_BITS-1:0]       req_cyl,
   input  logic                      cfg_we,
   input  dsched_pkg::csr_index_type cfg_idx,
   input  logic [CYL_BITS-1:0]       cfg_data,
   output logic [CYL_BITS-1:0]       served,
   output logic [31:0]               movement
);

   localparam int unsigned IB = $clog2(POOL_DEPTH);
   localparam int unsigned CB = $clog2(POOL_DEPTH + 1);

   logic [CYL_BITS-1:0] pool_ff [POOL_DEPTH];
   logic [CB-1:0] count_ff;
   logic [IB-1:0] scan_ff, shift_ff;
   logic [2:0] policy_ff;
   logic [CYL_BITS-1:0] top_ff, head_ff;
   logic up_dir_ff;
   logic [31:0] total_ff;
   // search bests: up from head, down from head, lowest, highest, nearest
   logic upv_ff, dnv_ff;
   logic [IB-1:0] upi_ff, dni_ff, loi_ff, hii_ff, nri_ff;
   logic [CYL_BITS-1:0] upc_ff, dnc_ff, loc_ff, hic_ff, nrd_ff, nrc_ff;
   logic [CYL_BITS-1:0] c_cur, d_cur;

   assign c_cur = pool_ff[scan_ff];
   assign d_cur = (c_cur > head_ff) ? c_cur - head_ff : head_ff - c_cur;

   assign status.pool_full = count_ff == CB'(POOL_DEPTH);
   assign status.pool_empty = count_ff == '0;
   assign status.pool_one = count_ff == CB'(1);
   assign status.scan_last = CB'(scan_ff) + 1'b1 >= count_ff;
   assign status.shift_last = CB'(shift_ff) + 1'b1 >= count_ff;

   // choice made at pick time
   logic [IB-1:0] sel_i;
   logic [CYL_BITS-1:0] sel_c, turn;
   logic [CYL_BITS+1:0] seek_len;
   logic new_dir;
   logic [32:0] sum;

   always_comb begin
      turn = (top_ff > head_ff) ? top_ff : head_ff;
      sel_i = '0;
      sel_c = pool_ff[0];
      new_dir = up_dir_ff;
      seek_len = '0;
      case (policy_ff)
         dsched_pkg::POL_SSTF: begin
            sel_i = nri_ff;
            sel_c = nrc_ff;
         end
         dsched_pkg::POL_SCAN, dsched_pkg::POL_LOOK: begin
            if (up_dir_ff) begin
               if (upv_ff) begin
                  sel_i = upi_ff; sel_c = upc_ff;
               end else begin
                  sel_i = hii_ff; sel_c = hic_ff; new_dir = 1'b0;
                  if (policy_ff == dsched_pkg::POL_SCAN)
                     seek_len = (CYL_BITS+2)'(turn - head_ff)
                              + (CYL_BITS+2)'(turn - hic_ff);
               end
            end else begin
               if (dnv_ff) begin
                  sel_i = dni_ff; sel_c = dnc_ff;
               end else begin
                  sel_i = loi_ff; sel_c = loc_ff; new_dir = 1'b1;
                  if (policy_ff == dsched_pkg::POL_SCAN)
                     seek_len = (CYL_BITS+2)'(head_ff) + (CYL_BITS+2)'(loc_ff);
               end
            end
         end
         dsched_pkg::POL_CSCAN, dsched_pkg::POL_CLOOK: begin
            new_dir = 1'b1;
            if (upv_ff) begin
               sel_i = upi_ff; sel_c = upc_ff;
            end else begin
               sel_i = loi_ff; sel_c = loc_ff;
               if (policy_ff == dsched_pkg::POL_CSCAN)
                  seek_len = (CYL_BITS+2)'(turn - head_ff) + (CYL_BITS+2)'(turn)
                           + (CYL_BITS+2)'(loc_ff);
            end
         end
         default: begin
            sel_i = '0;
            sel_c = pool_ff[0];
         end
      endcase
      if (seek_len == '0)
         seek_len = (CYL_BITS+2)'((sel_c > head_ff) ? sel_c - head_ff : head_ff - sel_c);
      sum = {1'b0, total_ff} + 33'(seek_len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         policy_ff <= dsched_pkg::POL_FCFS;
         top_ff <= CYL_BITS'(dsched_pkg::TOP_RESET);
         head_ff <= CYL_BITS'(dsched_pkg::START_RESET);
         up_dir_ff <= 1'b1;
         total_ff <= '0;
         scan_ff <= '0;
         shift_ff <= '0;
      end else begin
         if (cfg_we) begin
            case (cfg_idx)
               dsched_pkg::CSR_POLICY: policy_ff <= cfg_data[2:0];
               dsched_pkg::CSR_START:  head_ff <= cfg_data;
               dsched_pkg::CSR_TOP:    top_ff <= cfg_data;
               default: ;
            endcase
         end
         if (cmd.store) count_ff <= count_ff + 1'b1;
         if (cmd.scan_start) scan_ff <= '0;
         if (cmd.scan_step && !status.scan_last) scan_ff <= scan_ff + 1'b1;
         if (cmd.pick) begin
            head_ff <= sel_c;
            up_dir_ff <= new_dir;
            total_ff <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            shift_ff <= sel_i;
         end
         if (cmd.shift_step) shift_ff <= shift_ff + 1'b1;
         if (cmd.shift_done) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) pool_ff[count_ff[IB-1:0]] <= req_cyl;
      if (cmd.shift_step) pool_ff[shift_ff] <= pool_ff[shift_ff + 1'b1];
      if (cmd.pick) served <= sel_c;
      if (cmd.scan_start) begin
         upv_ff <= 1'b0;
         dnv_ff <= 1'b0;
      end
      if (cmd.scan_step) begin
         if (scan_ff == '0 || c_cur < loc_ff) begin
            loi_ff <= scan_ff; loc_ff <= c_cur;
         end
         if (scan_ff == '0 || c_cur > hic_ff) begin
            hii_ff <= scan_ff; hic_ff <= c_cur;
         end
         if (scan_ff == '0 || d_cur < nrd_ff) begin
            nri_ff <= scan_ff; nrd_ff <= d_cur; nrc_ff <= c_cur;
         end
         if (c_cur >= head_ff && (!upv_ff || c_cur < upc_ff)) begin
            upv_ff <= 1'b1; upi_ff <= scan_ff; upc_ff <= c_cur;
         end
         if (c_cur <= head_ff && (!dnv_ff || c_cur > dnc_ff)) begin
            dnv_ff <= 1'b1; dni_ff <= scan_ff; dnc_ff <= c_cur;
         end
      end
   end

   assign movement = total_ff;

   // pool never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(POOL_DEPTH))
      else $error("pool count overflow");
   // service only with a non-empty pool
   assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> count_ff != '0)
      else $error("service of empty pool");
   // total never decreases across a service
   assert property (@(posedge clock) disable iff (reset)
      cmd.pick && !cfg_we |=> total_ff >= $past(total_ff))
      else $error("head movement decreased");

endmodule

// File: src/disk_request_scheduler.sv
// top level of the disk request scheduler
// depends on dsched_pkg, dsched_ctrl and dsched_dp
//
// usage:
// - req channel (req_valid, req_stall, req_word) carries one request word:
//   cylinder and end_of_requests. rsp channel (rsp_valid, rsp_stall,
//   rsp_word) carries served_cylinder, head_movement and run_last
// - csr channel writes policy, start cylinder (also loads the head) and top
//   cylinder; write only while idle
// - an arrival into a pool that is not full is stored and gives no word; a
//   full pool first serves one request, an end-marked arrival drains the
//   pool, one word per request, run_last on the final one
// - one service is a serial scan of the pool, a pick, then a serial shift
//   that closes the gap, and then the output state
// - the controller works on one request at a time; req_stall is high from
//   acceptance of a serving arrival until its last word is taken
// - a stalled result word holds, and the block waits in its output state
// - synchronous reset empties the pool, zeroes head movement, sets the
//   sweep upward and loads register resets (policy fcfs, start 5000,
//   top 9999)
module disk_request_scheduler #(
   parameter int unsigned POOL_DEPTH = dsched_pkg::POOL_DEPTH_DEF,
   parameter int unsigned CYL_BITS = dsched_pkg::CYL_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  dsched_pkg::req_word_type                req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output dsched_pkg::rsp_word_type                rsp_word,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dsched_pkg::CSR_ADDR_BITS-1:0]    csr_index,
   input  logic [dsched_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   dsched_pkg::dp_cmd_type cmd;
   dsched_pkg::dp_status_type status;
   logic rsp_last;
   logic [CYL_BITS-1:0] served;
   logic [31:0] movement;

   // configuration always taken; writes must come only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   dsched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_end   (req_word.end_of_requests),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_last  (rsp_last),
      .cmd       (cmd),
      .status    (status)
   );

   // arrival word is latched so a served-first arrival is stored afterward
   logic [CYL_BITS-1:0] hold_cyl_ff;
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) hold_cyl_ff <= CYL_BITS'(req_word.cylinder);
   end

   logic [CYL_BITS-1:0] store_cyl;
   assign store_cyl = req_stall ? hold_cyl_ff : CYL_BITS'(req_word.cylinder);

   dsched_dp #(
      .POOL_DEPTH (POOL_DEPTH),
      .CYL_BITS   (CYL_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_cyl  (store_cyl),
      .cfg_we   (csr_valid && csr_ready),
      .cfg_idx  (dsched_pkg::csr_index_type'(csr_index)),
      .cfg_data (csr_data[CYL_BITS-1:0]),
      .served   (served),
      .movement (movement)
   );

   assign rsp_word.served_cylinder = dsched_pkg::CYL_BITS_DEF'(served);
   assign rsp_word.head_movement = movement;
   assign rsp_word.run_last = rsp_last;

endmodule

// File: test/disk_request_scheduler_test.sv
// testbench for the disk request scheduler
// drives request words, checks result words against its own scheduler model
// depends on dsched_pkg and disk_request_scheduler
`timescale 1ns / 100ps

module disk_request_scheduler_test;

   localparam int unsigned POOL = dsched_pkg::POOL_DEPTH_DEF;
   localparam int unsigned CYL_MAX = (1 << dsched_pkg::CYL_BITS_DEF) - 1;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dsched_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dsched_pkg::rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dsched_pkg::CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [dsched_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   disk_request_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // scheduler model state, mirrors what the block should hold
   dsched_pkg::policy_type mdl_policy;
   logic [13:0] mdl_start, mdl_top, mdl_head;
   logic mdl_upward;
   logic [31:0] mdl_total;
   logic [13:0] mdl_pool [$];

   dsched_pkg::rsp_word_type served_queue [$];
   int mismatches = 0;
   int words_checked = 0;
   int requests_sent = 0;
   int cycle_count = 0;
   bit hold_receiver = 1'b0;
   bit random_idle = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL disk_request_scheduler");
         $finish;
      end
   end

   // smallest cylinder at or above h, oldest on tie; -1 if none
   function automatic int nearest_up(logic [13:0] h);
      int pick;
      pick = -1;
      for (int i = 0; i < mdl_pool.size(); i++)
         if (mdl_pool[i] >= h && (pick < 0 || mdl_pool[i] < mdl_pool[pick])) pick = i;
      return pick;
   endfunction

   // largest cylinder at or below h, oldest on tie; -1 if none
   function automatic int nearest_down(logic [13:0] h);
      int pick;
      pick = -1;
      for (int i = 0; i < mdl_pool.size(); i++)
         if (mdl_pool[i] <= h && (pick < 0 || mdl_pool[i] > mdl_pool[pick])) pick = i;
      return pick;
   endfunction

   function automatic longint unsigned gap(logic [13:0] a, logic [13:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // serve one pending request under the current policy, queue the word
   task automatic serve_request(bit is_last);
      logic [13:0] h, turn, cyl;
      longint unsigned seek_len, sum;
      int idx;
      dsched_pkg::rsp_word_type w;
      h = mdl_head;
      turn = (mdl_top > h) ? mdl_top : h;
      seek_len = 0;
      idx = 0;
      case (mdl_policy)
         dsched_pkg::POL_SSTF: begin
            for (int i = 1; i < mdl_pool.size(); i++)
               if (gap(mdl_pool[i], h) < gap(mdl_pool[idx], h)) idx = i;
         end
         dsched_pkg::POL_SCAN, dsched_pkg::POL_LOOK: begin
            if (mdl_upward) begin
               idx = nearest_up(h);
               if (idx < 0) begin
                  idx = nearest_down(14'(CYL_MAX));
                  mdl_upward = 1'b0;
                  if (mdl_policy == dsched_pkg::POL_SCAN)
                     seek_len = longint'(turn - h) + longint'(turn - mdl_pool[idx]);
               end
            end else begin
               idx = nearest_down(h);
               if (idx < 0) begin
                  idx = nearest_up(14'd0);
                  mdl_upward = 1'b1;
                  if (mdl_policy == dsched_pkg::POL_SCAN)
                     seek_len = longint'(h) + mdl_pool[idx];
               end
            end
         end
         dsched_pkg::POL_CSCAN: begin
            mdl_upward = 1'b1;
            idx = nearest_up(h);
            if (idx < 0) begin
               idx = nearest_up(14'd0);
               seek_len = longint'(turn - h) + turn + mdl_pool[idx];
            end
         end
         dsched_pkg::POL_CLOOK: begin
            mdl_upward = 1'b1;
            idx = nearest_up(h);
            if (idx < 0) idx = nearest_up(14'd0);
         end
         default: idx = 0;
      endcase
      if (idx < 0) idx = 0;
      cyl = mdl_pool[idx];
      if (seek_len == 0) seek_len = gap(cyl, h);
      sum = longint'(mdl_total) + seek_len;
      mdl_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      mdl_head = cyl;
      mdl_pool.delete(idx);
      w.served_cylinder = cyl;
      w.head_movement = mdl_total;
      w.run_last = is_last;
      served_queue.push_back(w);
   endtask

   // expected words for one accepted request
   task automatic predict_request(dsched_pkg::req_word_type r);
      if (mdl_pool.size() >= POOL) serve_request(!r.end_of_requests);
      mdl_pool.push_back(r.cylinder);
      if (r.end_of_requests)
         while (mdl_pool.size() > 0) serve_request(mdl_pool.size() == 1);
   endtask

   // result checker, samples at the rising edge
   always @(posedge clock) begin
      dsched_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (served_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", rsp_word);
         end else begin
            want = served_queue.pop_front();
            if (rsp_word.served_cylinder !== want.served_cylinder
                || rsp_word.head_movement !== want.head_movement
                || rsp_word.run_last !== want.run_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: cyl %0d/%0d move %0d/%0d last %0b/%0b (exp/act)",
                           want.served_cylinder, rsp_word.served_cylinder,
                           want.head_movement, rsp_word.head_movement,
                           want.run_last, rsp_word.run_last);
            end
         end
      end
   end

   // receiver stall, random per word, or held by a long hold-off
   initial begin
      int waits;
      forever begin
         @(negedge clock);
         if (hold_receiver) begin
            rsp_stall <= 1'b1;
         end else if (random_idle && rsp_valid) begin
            waits = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) waits = 0;
            if (waits != 0) begin
               rsp_stall <= 1'b1;
               repeat (waits) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            // let the word go
            @(posedge clock);
            while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // send one request word, predicting on acceptance
   // valid stays up between words of a run unless a random wait comes first, and drops after the end-marked one
   task automatic send_request(logic [13:0] cyl, bit last_flag);
      dsched_pkg::req_word_type r;
      int waits;
      r.cylinder = cyl;
      r.end_of_requests = last_flag;
      waits = random_idle ? $urandom_range(0, 11) : 0;
      if (random_idle && $urandom_range(0, 2) == 0) waits = 0;
      if (waits != 0) begin
         req_valid <= 1'b0;
         repeat (waits) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(r);
      requests_sent++;
      @(negedge clock);
      if (last_flag) req_valid <= 1'b0;
   endtask

   task automatic wait_drained;
      while (served_queue.size() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // register write, only while idle
   task automatic write_register(dsched_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dsched_pkg::CSR_POLICY: mdl_policy = dsched_pkg::policy_type'(value[2:0]);
         dsched_pkg::CSR_START: begin
            mdl_start = value[13:0];
            mdl_head = value[13:0];
         end
         dsched_pkg::CSR_TOP: mdl_top = value[13:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_run(int count, int cyl_hi);
      for (int i = 0; i < count; i++)
         send_request(14'($urandom_range(0, cyl_hi)), (i == count - 1));
   endtask

   // extremes, ties and the unused policy codes under fcfs and sstf
   task automatic test_directed;
      write_register(dsched_pkg::CSR_POLICY, 32'(dsched_pkg::POL_SSTF));
      send_request(14'd0, 1'b0);
      send_request(14'(CYL_MAX), 1'b0);
      send_request(14'd5000, 1'b0);
      send_request(14'd4990, 1'b0);
      send_request(14'd5010, 1'b0);
      send_request(14'd5010, 1'b1);
      wait_drained();
      write_register(dsched_pkg::CSR_POLICY, 32'(dsched_pkg::POL_RSV7));
      send_request(14'h2AAA, 1'b0);
      send_request(14'h1555, 1'b1);
      wait_drained();
      write_register(dsched_pkg::CSR_POLICY, 32'(dsched_pkg::POL_RSV6));
      send_request(14'd7, 1'b1);
      wait_drained();
   endtask

   // each policy draining a partly filled pool, top at 1 for scan and at the maximum cylinder for cscan
   task automatic test_policies;
      for (int p = 0; p < 6; p++) begin
         write_register(dsched_pkg::CSR_POLICY, p);
         write_register(dsched_pkg::CSR_START, $urandom_range(0, CYL_MAX));
         write_register(dsched_pkg::CSR_TOP,
                        (p == 2) ? 1 : (p == 3 ? CYL_MAX : $urandom_range(1, CYL_MAX)));
         random_run(10, CYL_MAX);
         wait_drained();
      end
   endtask

   // receiver held off while the sender fills the pool
   task automatic test_backpressure;
      write_register(dsched_pkg::CSR_POLICY, 32'(dsched_pkg::POL_LOOK));
      hold_receiver = 1'b1;
      fork
         random_run(POOL + 6, 300);
         begin
            repeat (600) @(negedge clock);
            hold_receiver = 1'b0;
         end
      join
      wait_drained();
   endtask

   // random policies and sizes, no idling for part of it
   task automatic test_random;
      for (int k = 0; k < 4; k++) begin
         random_idle = (k != 1);
         write_register(dsched_pkg::CSR_POLICY, $urandom_range(0, 7));
         write_register(dsched_pkg::CSR_TOP, $urandom_range(1, CYL_MAX));
         random_run($urandom_range(4, 10), (k == 2) ? 40 : CYL_MAX);
         wait_drained();
      end
      random_idle = 1'b1;
   endtask

   initial begin
      mdl_policy = dsched_pkg::POL_FCFS;
      mdl_start = dsched_pkg::START_RESET;
      mdl_top = dsched_pkg::TOP_RESET;
      mdl_head = dsched_pkg::START_RESET;
      mdl_upward = 1'b1;
      mdl_total = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_policies();
      test_backpressure();
      test_random();
      wait_drained();
      $display("covered %0d requests and %0d result words", requests_sent, words_checked);
      $display("across all six policies, ties, extremes and a long receiver hold-off");
      if (mismatches == 0 && served_queue.size() == 0) begin
         $display("PASS disk_request_scheduler");
      end else begin
         $display("%0d mismatches, %0d words missing", mismatches, served_queue.size());
         $display("FAIL disk_request_scheduler");
      end
      $finish;
   end

endmodule

// File: disk_request_scheduler.f
src/dsched_pkg.sv
src/dsched_ctrl.sv
src/dsched_dp.sv
src/disk_request_scheduler.sv
test/disk_request_scheduler_test.sv
